// ----- rtl/core/qpa_pkg.sv -----
`default_nettype none

package qpa_pkg;

   localparam int STEP_BITS   = 3;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COS_STEP       = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIN_STEP       = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_STEP      = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAN_LEFT       = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAN_RIGHT      = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_COS_PART = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_SIN_PART = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_GAIN     = 4'd7;

   typedef struct packed {
      logic signed [31:0] left_in;
      logic signed [31:0] right_in;
      logic               restart;
      logic               block_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] left_out;
      logic signed [31:0] right_out;
      logic signed [31:0] phase_cos_now;
      logic signed [31:0] phase_sin_now;
      logic signed [31:0] gain_now;
      logic               last_out;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] cos_step;
      logic signed [31:0] sin_step;
      logic signed [31:0] gain_step;
      logic signed [31:0] pan_left;
      logic signed [31:0] pan_right;
      logic signed [31:0] start_cos_part;
      logic signed [31:0] start_sin_part;
      logic signed [31:0] start_gain;
   } cfg_type;

   typedef enum logic [1:0] {
      OPA_GAIN,
      OPA_V,
      OPA_COS,
      OPA_SIN
   } opa_type;

   typedef enum logic [2:0] {
      OPB_SIN,
      OPB_PAN_LEFT,
      OPB_PAN_RIGHT,
      OPB_COS_STEP,
      OPB_SIN_STEP
   } opb_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_NCOS_SET,
      ACC_V_SET,
      ACC_NCOS_SUB,
      ACC_LEFT_ADD,
      ACC_RIGHT_ADD,
      ACC_NSIN_SET
   } acc_type;

   typedef enum logic {
      JMP_NEXT,
      JMP_DONE_WHEN_FREE
   } jmp_type;

   typedef struct packed {
      logic    mul_en;
      opa_type mul_a;
      opb_type mul_b;
      acc_type acc_op;
      logic    gain_add;
      logic    commit;
      jmp_type jmp;
   } ucode_type;

   typedef struct packed {
      logic      active;
      logic      fire;
      ucode_type word;
   } ctrl_type;

   // steps 0 to 6 each issue one product; steps 1 to 7 each retire the one issued a step earlier
   function automatic ucode_type ucode_rom(input logic [STEP_BITS-1:0] addr);
      ucode_type w;
      w = '{mul_en: 1'b0, mul_a: OPA_GAIN, mul_b: OPB_SIN, acc_op: ACC_NONE,
            gain_add: 1'b0, commit: 1'b0, jmp: JMP_NEXT};
      case (addr)
         3'd0: begin
            w.mul_en = 1'b1; w.mul_a = OPA_COS; w.mul_b = OPB_COS_STEP;
            w.gain_add = 1'b1;
         end
         3'd1: begin
            w.mul_en = 1'b1; w.mul_a = OPA_GAIN; w.mul_b = OPB_SIN;
            w.acc_op = ACC_NCOS_SET;
         end
         3'd2: begin
            w.mul_en = 1'b1; w.mul_a = OPA_SIN; w.mul_b = OPB_SIN_STEP;
            w.acc_op = ACC_V_SET;
         end
         3'd3: begin
            w.mul_en = 1'b1; w.mul_a = OPA_V; w.mul_b = OPB_PAN_LEFT;
            w.acc_op = ACC_NCOS_SUB;
         end
         3'd4: begin
            w.mul_en = 1'b1; w.mul_a = OPA_V; w.mul_b = OPB_PAN_RIGHT;
            w.acc_op = ACC_LEFT_ADD;
         end
         3'd5: begin
            w.mul_en = 1'b1; w.mul_a = OPA_COS; w.mul_b = OPB_SIN_STEP;
            w.acc_op = ACC_RIGHT_ADD;
         end
         3'd6: begin
            w.mul_en = 1'b1; w.mul_a = OPA_SIN; w.mul_b = OPB_COS_STEP;
            w.acc_op = ACC_NSIN_SET;
         end
         3'd7: begin
            w.commit = 1'b1; w.jmp = JMP_DONE_WHEN_FREE;
         end
         default: begin
            w.jmp = JMP_DONE_WHEN_FREE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qpa_sequencer.sv -----
`default_nettype none

module qpa_sequencer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             out_hold,
   output logic                  busy,
   output qpa_pkg::ctrl_type     ctrl
);

   logic                           busy_ff, busy_in;
   logic [qpa_pkg::STEP_BITS-1:0]  step_ff, step_in;
   qpa_pkg::ucode_type             word;

   always_comb begin
      word = qpa_pkg::ucode_rom(step_ff);
   end

   always_comb begin
      ctrl.active = busy_ff;
      ctrl.word   = busy_ff ? word : '0;
      ctrl.fire   = busy_ff && word.commit && !out_hold;
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         case (word.jmp)
            qpa_pkg::JMP_NEXT: begin
               step_in = step_ff + 1'b1;
            end
            qpa_pkg::JMP_DONE_WHEN_FREE: begin
               if (!out_hold) begin
                  busy_in = 1'b0;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy = busy_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && step_ff == '0))
      else $error("request accepted but program did not start at step zero");

   a_fire_ends: assert property (@(posedge clock) disable iff (reset)
      ctrl.fire |=> !busy_ff)
      else $error("sequencer still busy after result commit");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !accept)
      else $error("request accepted while program running");

endmodule

`default_nettype wire

// ----- rtl/core/qpa_datapath.sv -----
`default_nettype none

module qpa_datapath #(
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire qpa_pkg::req_type  req,
   input  wire qpa_pkg::cfg_type  cfg,
   input  wire qpa_pkg::ctrl_type ctrl,
   output qpa_pkg::rsp_type       result
);

   localparam int MIX_BITS = (SAMPLE_BITS > 32) ? 32 : SAMPLE_BITS;
   localparam logic signed [32:0] MIX_HI = (33'sd1 <<< (MIX_BITS - 1)) - 33'sd1;
   localparam logic signed [32:0] MIX_LO = -MIX_HI - 33'sd1;
   localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
   localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;
   localparam logic signed [63:0] RND_HALF = 64'sd536870912;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[31:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_mix(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > MIX_HI) begin
         r = MIX_HI[31:0];
      end else if (v < MIX_LO) begin
         r = MIX_LO[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic signed [31:0] cos_ff, cos_in, sin_ff, sin_in, gain_ff, gain_in;
   logic signed [31:0] v_ff, v_in, ncos_ff, ncos_in, nsin_ff, nsin_in;
   logic signed [31:0] left_ff, left_in, right_ff, right_in;
   logic               last_ff, last_in;
   logic signed [63:0] prod_ff, prod_in;

   logic signed [31:0] op_a, op_b, rnd, gain_sum, ncos_sub, nsin_add;
   logic signed [31:0] left_sum, right_sum;
   logic signed [63:0] rnd_sum;

   always_comb begin
      case (ctrl.word.mul_a)
         qpa_pkg::OPA_GAIN: op_a = gain_ff;
         qpa_pkg::OPA_V:    op_a = v_ff;
         qpa_pkg::OPA_COS:  op_a = cos_ff;
         qpa_pkg::OPA_SIN:  op_a = sin_ff;
         default:           op_a = gain_ff;
      endcase
      case (ctrl.word.mul_b)
         qpa_pkg::OPB_SIN:       op_b = sin_ff;
         qpa_pkg::OPB_PAN_LEFT:  op_b = cfg.pan_left;
         qpa_pkg::OPB_PAN_RIGHT: op_b = cfg.pan_right;
         qpa_pkg::OPB_COS_STEP:  op_b = cfg.cos_step;
         qpa_pkg::OPB_SIN_STEP:  op_b = cfg.sin_step;
         default:                op_b = sin_ff;
      endcase
   end

   // round half up at bit 30, then saturate; the gain, phasor and mix sums saturate too
   always_comb begin
      rnd_sum   = prod_ff + RND_HALF;
      rnd       = sat32($signed(rnd_sum[63:30]));
      gain_sum  = sat32(34'(gain_ff) + 34'(cfg.gain_step));
      ncos_sub  = sat32(34'(ncos_ff) - 34'(rnd));
      nsin_add  = sat32(34'(nsin_ff) + 34'(rnd));
      left_sum  = sat_mix(33'(left_ff) + 33'(rnd));
      right_sum = sat_mix(33'(right_ff) + 33'(rnd));
   end

   always_comb begin
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      gain_in  = gain_ff;
      v_in     = v_ff;
      ncos_in  = ncos_ff;
      nsin_in  = nsin_ff;
      left_in  = left_ff;
      right_in = right_ff;
      last_in  = last_ff;
      prod_in  = prod_ff;
      if (accept) begin
         left_in  = req.left_in;
         right_in = req.right_in;
         last_in  = req.block_end;
         if (req.restart) begin
            cos_in  = cfg.start_cos_part;
            sin_in  = cfg.start_sin_part;
            gain_in = cfg.start_gain;
         end
      end
      if (ctrl.active) begin
         if (ctrl.word.gain_add) begin
            gain_in = gain_sum;
         end
         if (ctrl.word.mul_en) begin
            prod_in = 64'(op_a) * 64'(op_b);
         end
         case (ctrl.word.acc_op)
            qpa_pkg::ACC_NCOS_SET:  ncos_in  = rnd;
            qpa_pkg::ACC_V_SET:     v_in     = rnd;
            qpa_pkg::ACC_NCOS_SUB:  ncos_in  = ncos_sub;
            qpa_pkg::ACC_LEFT_ADD:  left_in  = left_sum;
            qpa_pkg::ACC_RIGHT_ADD: right_in = right_sum;
            qpa_pkg::ACC_NSIN_SET:  nsin_in  = rnd;
            default: begin
            end
         endcase
      end
      if (ctrl.fire) begin
         cos_in = ncos_ff;
         sin_in = nsin_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff  <= '0;
         sin_ff  <= '0;
         gain_ff <= '0;
      end else begin
         cos_ff  <= cos_in;
         sin_ff  <= sin_in;
         gain_ff <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      ncos_ff  <= ncos_in;
      nsin_ff  <= nsin_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      last_ff  <= last_in;
      prod_ff  <= prod_in;
   end

   always_comb begin
      result.left_out      = left_ff;
      result.right_out     = right_ff;
      result.phase_cos_now = ncos_ff;
      result.phase_sin_now = nsin_add;
      result.gain_now      = gain_ff;
      result.last_out      = last_ff;
   end

endmodule

`default_nettype wire

// ----- rtl/core/quadrature_partial_accumulator.sv -----
// One sinusoidal partial from a recursive quadrature phasor, panned into a stereo mix.
// Each request carries the left and right mix samples; the response returns the mixed
// samples, the rotated phasor and the stepped gain. A single 32x32 multiplier is shared
// by the seven products of a frame under a microcode program of eight steps, so a new
// request is taken only once the program has ended; req_stall stays high while the program
// runs. The response sits in an output register; if the last one has not been taken, the
// last step waits until it is. Mix sums saturate to min(SAMPLE_BITS, 32) bits.
`default_nettype none

module quadrature_partial_accumulator #(
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire qpa_pkg::req_type                      req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output qpa_pkg::rsp_type                           rsp_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [qpa_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [31:0]                           csr_wdata
);

   qpa_pkg::cfg_type  cfg_ff, cfg_in;
   qpa_pkg::ctrl_type ctrl;
   qpa_pkg::rsp_type  result;
   qpa_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              busy, accept, out_hold;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign out_hold  = rsp_valid_ff && rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            qpa_pkg::CSR_COS_STEP:       cfg_in.cos_step       = csr_wdata;
            qpa_pkg::CSR_SIN_STEP:       cfg_in.sin_step       = csr_wdata;
            qpa_pkg::CSR_GAIN_STEP:      cfg_in.gain_step      = csr_wdata;
            qpa_pkg::CSR_PAN_LEFT:       cfg_in.pan_left       = csr_wdata;
            qpa_pkg::CSR_PAN_RIGHT:      cfg_in.pan_right      = csr_wdata;
            qpa_pkg::CSR_START_COS_PART: cfg_in.start_cos_part = csr_wdata;
            qpa_pkg::CSR_START_SIN_PART: cfg_in.start_sin_part = csr_wdata;
            qpa_pkg::CSR_START_GAIN:     cfg_in.start_gain     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_step       <= 32'sh4000_0000;
         cfg_ff.sin_step       <= '0;
         cfg_ff.gain_step      <= '0;
         cfg_ff.pan_left       <= '0;
         cfg_ff.pan_right      <= '0;
         cfg_ff.start_cos_part <= 32'sh4000_0000;
         cfg_ff.start_sin_part <= '0;
         cfg_ff.start_gain     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qpa_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .out_hold (out_hold),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   qpa_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .ctrl   (ctrl),
      .result (result)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (ctrl.fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fire_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      ctrl.fire |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.fire |-> !(rsp_valid_ff && rsp_stall))
      else $error("result committed over a held response");

   a_held_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("held response changed");

endmodule

`default_nettype wire
